// ----- hw/rtl/abs_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// abs_pkg
// shared constants and types of the background segmenter
// ----------------------------------------------------------------------------
package abs_pkg;

	localparam int unsigned PIXELS     = 65536;
	localparam int unsigned MAX_FRAMES = 64;
	localparam int unsigned PIX_W      = 16;
	localparam int unsigned ADDR_W     = (PIXELS > 1) ? $clog2(PIXELS) : 1;
	localparam int unsigned SUM_W      = 14;
	localparam int unsigned SUM_MAX    = (1 << SUM_W) - 1;
	localparam int unsigned CNT_W      = $clog2(MAX_FRAMES + 1);
	localparam int unsigned LOG_F      = $clog2(MAX_FRAMES);
	localparam int unsigned IDX_W      = (LOG_F > 0) ? LOG_F : 1;
	// rounded numerator: sum plus half the count
	localparam int unsigned NUM_W      = SUM_W + 1;
	// reciprocal shift that keeps the product exact for every numerator
	localparam int unsigned RSH        = NUM_W + LOG_F;
	localparam int unsigned REC_W      = RSH + 1;
	localparam int unsigned PROD_W     = NUM_W + REC_W;
	localparam int unsigned SCALE_W    = 5;

	typedef enum logic [1:0] {
		OP_LEARN   = 2'd0,
		OP_BUILD   = 2'd1,
		OP_SEGMENT = 2'd2,
		OP_NONE    = 2'd3
	} op_t;

	typedef enum logic {
		REG_HIGH_SCALE = 1'b0,
		REG_LOW_SCALE  = 1'b1
	} reg_idx_t;

	typedef logic [2:0][7:0] ch3_t;

	typedef struct packed {
		ch3_t                  prev;
		logic [2:0][SUM_W-1:0] sum;
		logic [2:0][SUM_W-1:0] dif;
	} hist_t;

	typedef struct packed {
		ch3_t lo;
		ch3_t hi;
	} bounds_t;

	typedef struct packed {
		logic [PROD_W-1:0] avg_prod;
		logic [PROD_W-1:0] dif_prod;
	} prod_pair_t;

	typedef struct packed {
		logic [7:0] avg;
		logic [7:0] up;
		logic [7:0] down;
	} chan_terms_t;

endpackage
`default_nettype wire

// ----- hw/rtl/abs_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// abs_pix_if / abs_res_if
// request and result channels of the background segmenter
// ----------------------------------------------------------------------------
interface abs_pix_if;
	logic       valid;
	logic       ready;
	logic [1:0] operation;
	logic [15:0] pixel_index;
	logic [7:0] channel_0;
	logic [7:0] channel_1;
	logic [7:0] channel_2;
	logic       end_of_frame;

	modport source(output valid, operation, pixel_index, channel_0, channel_1, channel_2,
		end_of_frame, input ready);
	modport sink(input valid, operation, pixel_index, channel_0, channel_1, channel_2,
		end_of_frame, output ready);
endinterface

interface abs_res_if;
	logic        valid;
	logic        ready;
	logic        foreground;
	logic [15:0] pixel_out;

	modport source(output valid, foreground, pixel_out, input ready);
	modport sink(input valid, foreground, pixel_out, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/abs_spread.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// abs_spread
// one channel: quotients from reciprocal products, clamped average and
// scaled spread terms
// ----------------------------------------------------------------------------
module abs_spread (
	input  abs_pkg::prod_pair_t           prods,
	input  logic [abs_pkg::SCALE_W-1:0]   high_scale,
	input  logic [abs_pkg::SCALE_W-1:0]   low_scale,
	output abs_pkg::chan_terms_t          terms
);
	localparam int unsigned MW = abs_pkg::SCALE_W + 8;

	logic [abs_pkg::NUM_W-1:0] q_avg;
	logic [abs_pkg::NUM_W-1:0] q_dif;
	logic [abs_pkg::NUM_W:0]   spread_w;
	logic [7:0]                spread;
	logic [MW-1:0]             up_w;
	logic [MW-1:0]             down_w;

	always_comb begin
		q_avg    = abs_pkg::NUM_W'(prods.avg_prod >> abs_pkg::RSH);
		q_dif    = abs_pkg::NUM_W'(prods.dif_prod >> abs_pkg::RSH);
		spread_w = {1'b0, q_dif} + (abs_pkg::NUM_W+1)'(1);
		spread   = (spread_w > (abs_pkg::NUM_W+1)'(255)) ? 8'd255 : spread_w[7:0];
		up_w     = MW'(high_scale) * MW'(spread);
		down_w   = MW'(low_scale) * MW'(spread);
		terms.avg  = (q_avg > abs_pkg::NUM_W'(255)) ? 8'd255 : q_avg[7:0];
		terms.up   = (up_w > MW'(255)) ? 8'd255 : up_w[7:0];
		terms.down = (down_w > MW'(255)) ? 8'd255 : down_w[7:0];
	end
endmodule
`default_nettype wire

// ----- hw/rtl/average_background_segmenter.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// average_background_segmenter
// per-pixel frame averaging background model with learn, build and segment
// ----------------------------------------------------------------------------
// Takes one request per cycle unless the output stalls, and presents one result
// per request in order, through stages 1, 2 and 3 and the output register. The
// sums and previous pixel of each pixel live in one memory read at acceptance,
// updated in stage 1 and written back when stage 1 advances; the bounds live in
// a second memory written by build requests three stages in. A one-entry bypass
// on each memory covers back-to-back requests to the same pixel. Averages divide
// by the frame count through a reciprocal table and one multiply per term. After
// reset the history memory is cleared one entry a cycle over its 65536 entries,
// and no request is taken until that ends; register writes are taken at any time.
module average_background_segmenter (
	input  logic                          clk,
	input  logic                          arst_n,
	abs_pix_if.sink                       pixels,
	abs_res_if.source                     results,
	input  logic                          cfg_wen,
	input  logic                          cfg_index,
	input  logic [abs_pkg::SCALE_W-1:0]   cfg_data
);
	localparam int unsigned AW = abs_pkg::ADDR_W;
	localparam int unsigned CW = abs_pkg::CNT_W;
	localparam int unsigned SUM_W_P = abs_pkg::SUM_W;

	logic [abs_pkg::SCALE_W-1:0] high_scale_q, low_scale_q;
	logic [CW-1:0]               frames_q;
	logic                        first_q;
	logic                        clr_q;
	logic [AW-1:0]               clr_cnt_q;

	abs_pkg::hist_t   mem_a [abs_pkg::PIXELS];
	abs_pkg::bounds_t mem_b [abs_pkg::PIXELS];

	logic adv, acc;
	logic in_range;

	// stage 1
	logic                     v_s1, inr_s1, eof_s1;
	abs_pkg::op_t             op_s1;
	logic [abs_pkg::PIX_W-1:0] pix_s1;
	abs_pkg::ch3_t            ch_s1;
	abs_pkg::hist_t           rda_s1, byp_a_s1, hist_s1, hist_new;
	logic                     hit_a_s1;
	// stage 2
	logic                     v_s2, inr_s2, zero_s2;
	abs_pkg::op_t             op_s2;
	logic [abs_pkg::PIX_W-1:0] pix_s2;
	abs_pkg::ch3_t            ch_s2;
	abs_pkg::prod_pair_t [2:0] prod_s2;
	// stage 3
	logic                     v_s3, inr_s3, zero_s3;
	abs_pkg::op_t             op_s3;
	logic [abs_pkg::PIX_W-1:0] pix_s3;
	abs_pkg::ch3_t            ch_s3;
	abs_pkg::chan_terms_t [2:0] terms_s2, terms_s3;
	abs_pkg::bounds_t         rdb_s3, byp_b_s3, bnd_s3, bnd_new;
	logic                     hit_b_s3;
	// output
	logic                     out_v_q, fg_q;
	logic [abs_pkg::PIX_W-1:0] pix_q;
	logic                     fg_s3;

	logic                     wa_en;
	logic [AW-1:0]            wa_addr;
	abs_pkg::hist_t           wa_data;
	logic                     wb_en;
	logic                     learn_s1, count_s1;
	logic [abs_pkg::REC_W-1:0] recip_tab [abs_pkg::MAX_FRAMES];
	logic [abs_pkg::REC_W-1:0] recip;
	logic [CW-1:0]            n_m1;

	for (genvar g = 0; g < abs_pkg::MAX_FRAMES; g++) begin : g_rec
		localparam int unsigned R = ((2 ** abs_pkg::RSH) + g) / (g + 1);
		assign recip_tab[g] = abs_pkg::REC_W'(R);
	end

	assign adv      = !out_v_q || results.ready;
	assign pixels.ready = adv && !clr_q;
	assign acc      = pixels.valid && pixels.ready;
	assign in_range = {1'b0, pixels.pixel_index} < (abs_pkg::PIX_W+1)'(abs_pkg::PIXELS);

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			high_scale_q <= abs_pkg::SCALE_W'(7);
			low_scale_q  <= abs_pkg::SCALE_W'(6);
		end else if (cfg_wen) begin
			unique case (abs_pkg::reg_idx_t'(cfg_index))
				abs_pkg::REG_HIGH_SCALE: high_scale_q <= cfg_data;
				abs_pkg::REG_LOW_SCALE:  low_scale_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// clearing pass over the history memory
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= 1'b1;
			clr_cnt_q <= '0;
		end else if (clr_q) begin
			clr_cnt_q <= clr_cnt_q + AW'(1);
			if (clr_cnt_q == AW'(abs_pkg::PIXELS - 1))
				clr_q <= 1'b0;
		end
	end

	// stage 1: learn update with bypass of the previous write
	always_comb begin
		hist_s1  = hit_a_s1 ? byp_a_s1 : rda_s1;
		learn_s1 = v_s1 && inr_s1 && (op_s1 == abs_pkg::OP_LEARN);
		count_s1 = !first_q && (frames_q < CW'(abs_pkg::MAX_FRAMES));
		hist_new = hist_s1;
		hist_new.prev = ch_s1;
		for (int c = 0; c < 3; c++) begin
			logic [7:0]         d;
			logic [SUM_W_P:0]   sv;
			logic [SUM_W_P:0]   sd;
			d  = (ch_s1[c] > hist_s1.prev[c]) ? ch_s1[c] - hist_s1.prev[c]
				: hist_s1.prev[c] - ch_s1[c];
			sv = {1'b0, hist_s1.sum[c]} + (SUM_W_P+1)'(ch_s1[c]);
			sd = {1'b0, hist_s1.dif[c]} + (SUM_W_P+1)'(d);
			if (count_s1) begin
				hist_new.sum[c] = (sv > (SUM_W_P+1)'(abs_pkg::SUM_MAX))
					? abs_pkg::SUM_W'(abs_pkg::SUM_MAX) : sv[SUM_W_P-1:0];
				hist_new.dif[c] = (sd > (SUM_W_P+1)'(abs_pkg::SUM_MAX))
					? abs_pkg::SUM_W'(abs_pkg::SUM_MAX) : sd[SUM_W_P-1:0];
			end
		end
	end

	always_comb begin
		wa_en   = clr_q || (adv && learn_s1);
		wa_addr = clr_q ? clr_cnt_q : pix_s1[AW-1:0];
		wa_data = clr_q ? '0 : hist_new;
	end

	always_ff @(posedge clk) begin
		if (wa_en)
			mem_a[wa_addr] <= wa_data;
		if (acc) begin
			rda_s1   <= mem_a[pixels.pixel_index[AW-1:0]];
			byp_a_s1 <= wa_data;
			hit_a_s1 <= wa_en && (wa_addr == pixels.pixel_index[AW-1:0]);
		end
	end

	// frame counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frames_q <= '0;
			first_q  <= 1'b1;
		end else if (adv && learn_s1 && eof_s1) begin
			if (first_q)
				first_q <= 1'b0;
			else if (count_s1)
				frames_q <= frames_q + CW'(1);
		end
	end

	// reciprocal products of the rounded numerators
	always_comb begin
		n_m1  = (frames_q == '0) ? '0 : frames_q - CW'(1);
		recip = recip_tab[n_m1[abs_pkg::IDX_W-1:0]];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pix_s1 <= pixels.pixel_index;
			op_s1  <= abs_pkg::op_t'(pixels.operation);
			ch_s1  <= {pixels.channel_2, pixels.channel_1, pixels.channel_0};
			eof_s1 <= pixels.end_of_frame;
			inr_s1 <= in_range;
			pix_s2  <= pix_s1;
			op_s2   <= op_s1;
			ch_s2   <= ch_s1;
			inr_s2  <= inr_s1;
			zero_s2 <= (frames_q == '0);
			for (int c = 0; c < 3; c++) begin
				prod_s2[c].avg_prod <= abs_pkg::PROD_W'(
					({1'b0, hist_s1.sum[c]} + abs_pkg::NUM_W'(frames_q >> 1)) * recip);
				prod_s2[c].dif_prod <= abs_pkg::PROD_W'(
					({1'b0, hist_s1.dif[c]} + abs_pkg::NUM_W'(frames_q >> 1)) * recip);
			end
			pix_s3   <= pix_s2;
			op_s3    <= op_s2;
			ch_s3    <= ch_s2;
			inr_s3   <= inr_s2;
			zero_s3  <= zero_s2;
			terms_s3 <= terms_s2;
			pix_q    <= pix_s3;
			fg_q     <= fg_s3;
		end
	end

	// stage 2: quotients and scaled spreads
	for (genvar c = 0; c < 3; c++) begin : g_ch
		abs_spread u_spread (
			.prods      (prod_s2[c]),
			.high_scale (high_scale_q),
			.low_scale  (low_scale_q),
			.terms      (terms_s2[c])
		);
	end

	// stage 3: bounds and segmentation
	always_comb begin
		bnd_s3 = hit_b_s3 ? byp_b_s3 : rdb_s3;
		fg_s3  = v_s3 && inr_s3 && (op_s3 == abs_pkg::OP_SEGMENT);
		for (int c = 0; c < 3; c++) begin
			logic [8:0] hs;
			hs = {1'b0, terms_s3[c].avg} + {1'b0, terms_s3[c].up};
			if (ch_s3[c] >= bnd_s3.lo[c] && ch_s3[c] <= bnd_s3.hi[c])
				fg_s3 = 1'b0;
			if (zero_s3) begin
				bnd_new.hi[c] = 8'd0;
				bnd_new.lo[c] = 8'd0;
			end else begin
				bnd_new.hi[c] = hs[8] ? 8'd255 : hs[7:0];
				bnd_new.lo[c] = (terms_s3[c].avg > terms_s3[c].down)
					? terms_s3[c].avg - terms_s3[c].down : 8'd0;
			end
		end
		wb_en = adv && v_s3 && inr_s3 && (op_s3 == abs_pkg::OP_BUILD);
	end

	always_ff @(posedge clk) begin
		if (wb_en)
			mem_b[pix_s3[AW-1:0]] <= bnd_new;
		if (adv) begin
			rdb_s3   <= mem_b[pix_s2[AW-1:0]];
			byp_b_s3 <= bnd_new;
			hit_b_s3 <= wb_en && (pix_s3[AW-1:0] == pix_s2[AW-1:0]);
		end
	end

	// stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			out_v_q <= 1'b0;
		end else if (adv) begin
			v_s1    <= acc;
			v_s2    <= v_s1;
			v_s3    <= v_s2;
			out_v_q <= v_s3;
		end
	end

	assign results.valid      = out_v_q;
	assign results.foreground = fg_q;
	assign results.pixel_out  = pix_q;

`ifndef SYNTHESIS
	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr_q |-> !pixels.ready)
		else $error("request accepted during clearing pass");
	a_pipe_empty_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr_q |-> !(v_s1 || v_s2 || v_s3 || out_v_q))
		else $error("pipeline busy during clearing pass");
	a_frames_bound: assert property (@(posedge clk) disable iff (!arst_n)
		frames_q <= CW'(abs_pkg::MAX_FRAMES))
		else $error("frame counter past its limit");
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(v_s3) && $stable(pix_s3))
		else $error("pipeline moved while stalled");
`endif
endmodule
`default_nettype wire
